[rtl/led_strip_chase_sequencer_top_defines.svh]
// Assertion helpers used by the checker of this block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef LED_STRIP_CHASE_SEQUENCER_TOP_DEFINES_SVH
`define LED_STRIP_CHASE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication.
`define LSCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lscs check failed");

// Next-cycle implication.
`define LSCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lscs check failed");

`endif

[rtl/lscs_pkg.sv]
`default_nettype none

package lscs_pkg;

  localparam int PC_W     = 5;
  localparam int PAL_W    = 3;
  localparam int LEN_W    = 9;
  localparam int DIVD_W   = 16;
  localparam int DIVS_W   = 10;
  localparam int DCNT_W   = 4;
  localparam int MAX_RES  = 3;
  localparam int NCNT_W   = 2;

  localparam logic [PAL_W:0]   PALETTE_SIZE = 4'd7;
  localparam logic [LEN_W-1:0] MAX_LEDS     = 9'd256;
  localparam logic [LEN_W-1:0] MIN_LEN      = 9'd2;
  localparam logic [1:0]       CALLS_SAT    = 2'd2;

  localparam logic [1:0] MODE_CHASE = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_DOT   = 2'd2;
  localparam logic [1:0] MODE_ALT   = 2'd3;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_REVERSE   = 3'd1;
  localparam logic [2:0] REG_SEG_START = 3'd2;
  localparam logic [2:0] REG_SEG_STOP  = 3'd3;
  localparam logic [2:0] REG_SEG_LEN   = 3'd4;
  localparam logic [2:0] REG_SPEED     = 3'd5;
  localparam logic [2:0] REG_LED_COUNT = 3'd6;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_BLACK = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    C_NONE     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_MODE1    = 4'd2,
    C_MODE3    = 4'd3,
    C_CALLS0   = 4'd4,
    C_CALLS1   = 4'd5,
    C_STEP0    = 4'd6,
    C_STEPLT   = 4'd7,
    C_STEPLAST = 4'd8,
    C_CHASE    = 4'd9
  } cond_e;

  typedef enum logic [1:0] {
    PIX_NONE = 2'd0,
    PIX_HEAD = 2'd1,
    PIX_STEP = 2'd2,
    PIX_BACK = 2'd3
  } pix_sel_e;

  typedef enum logic [1:0] {
    COL_ZERO = 2'd0,
    COL_PAL  = 2'd1,
    COL_NEXT = 2'd2
  } col_sel_e;

  typedef enum logic [2:0] {
    DIV_NONE       = 3'd0,
    DIV_MOD_LEN    = 3'd1,
    DIV_MOD_LENP1  = 3'd2,
    DIV_DLY_LEDS   = 3'd3,
    DIV_DLY_LEDSP1 = 3'd4,
    DIV_DLY_LEDSM1 = 3'd5
  } div_op_e;

  typedef struct packed {
    cond_e             cond;
    logic              cond_inv;
    logic [PC_W-1:0]   target;
    logic              emit;
    act_e              act;
    pix_sel_e          pix;
    col_sel_e          col;
    logic              pal_next;
    logic              done_set;
    logic              phase_tgl;
    logic              step_set1;
    logic              dly_speed;
    div_op_e           div;
    logic              end_prog;
  } cw_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             reverse;
    logic [7:0]       seg_start;
    logic [7:0]       seg_stop;
    logic [LEN_W-1:0] seg_len;
    logic [15:0]      speed;
    logic [LEN_W-1:0] led_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  // Microprogram entry points
  localparam logic [PC_W-1:0] L_M1A  = 5'd3;
  localparam logic [PC_W-1:0] L_M1B  = 5'd6;
  localparam logic [PC_W-1:0] L_M1C  = 5'd9;
  localparam logic [PC_W-1:0] L_M1D  = 5'd12;
  localparam logic [PC_W-1:0] L_FSPD = 5'd13;
  localparam logic [PC_W-1:0] L_GEN  = 5'd14;
  localparam logic [PC_W-1:0] L_G1   = 5'd17;
  localparam logic [PC_W-1:0] L_G2   = 5'd20;
  localparam logic [PC_W-1:0] L_G3   = 5'd21;
  localparam logic [PC_W-1:0] L_DOT  = 5'd22;
  localparam logic [PC_W-1:0] L_DOTM = 5'd25;
  localparam logic [PC_W-1:0] L_GT   = 5'd26;
  localparam logic [PC_W-1:0] L_GDLY = 5'd28;
  localparam logic [PC_W-1:0] L_GD2  = 5'd30;
  localparam logic [PC_W-1:0] L_END  = 5'd31;

  function automatic cw_t lscs_rom(input logic [PC_W-1:0] pc);
    cw_t c;
    c = '0;
    unique case (pc)
      5'd0: begin
        c.cond = C_MODE1; c.cond_inv = 1'b1; c.target = L_GEN;
      end
      5'd1: begin
        c.cond = C_CALLS0; c.cond_inv = 1'b1; c.target = L_M1A;
      end
      5'd2: begin
        // first call in fill mode: fill strip, advance palette
        c.emit = 1'b1; c.act = ACT_FILL; c.col = COL_PAL; c.pal_next = 1'b1;
        c.cond = C_ALWAYS; c.target = L_FSPD;
      end
      L_M1A: begin
        c.cond = C_STEP0; c.cond_inv = 1'b1; c.target = L_M1B;
      end
      5'd4: begin
        c.emit = 1'b1; c.act = ACT_SET; c.pix = PIX_HEAD; c.col = COL_PAL;
        c.step_set1 = 1'b1;
        c.cond = C_CALLS1; c.cond_inv = 1'b1; c.target = L_M1B;
      end
      5'd5: begin
        c.cond = C_ALWAYS; c.target = L_FSPD;
      end
      L_M1B: begin
        c.cond = C_STEPLT; c.cond_inv = 1'b1; c.target = L_M1C;
      end
      5'd7: begin
        c.emit = 1'b1; c.act = ACT_SET; c.pix = PIX_STEP; c.col = COL_PAL;
        c.cond = C_STEPLAST; c.cond_inv = 1'b1; c.target = L_M1C;
      end
      5'd8: begin
        // pass ends: head takes the next color
        c.emit = 1'b1; c.act = ACT_SET; c.pix = PIX_HEAD; c.col = COL_NEXT;
      end
      L_M1C: begin
        c.div = DIV_MOD_LEN;
      end
      5'd10: begin
        c.cond = C_STEP0; c.cond_inv = 1'b1; c.target = L_M1D;
      end
      5'd11: begin
        c.done_set = 1'b1; c.pal_next = 1'b1;
      end
      L_M1D: begin
        c.div = DIV_DLY_LEDSM1; c.cond = C_ALWAYS; c.target = L_END;
      end
      L_FSPD: begin
        c.dly_speed = 1'b1; c.cond = C_ALWAYS; c.target = L_END;
      end
      L_GEN: begin
        c.cond = C_MODE3; c.cond_inv = 1'b1; c.target = L_G1;
      end
      5'd15: begin
        c.cond = C_STEP0; c.cond_inv = 1'b1; c.target = L_G1;
      end
      5'd16: begin
        c.emit = 1'b1; c.act = ACT_CLEAR;
      end
      L_G1: begin
        c.cond = C_CHASE; c.cond_inv = 1'b1; c.target = L_DOT;
      end
      5'd18: begin
        c.cond = C_STEPLT; c.target = L_G2;
      end
      5'd19: begin
        // blank frame
        c.emit = 1'b1; c.act = ACT_CLEAR; c.cond = C_ALWAYS; c.target = L_G3;
      end
      L_G2: begin
        c.emit = 1'b1; c.act = ACT_SET; c.pix = PIX_STEP; c.col = COL_PAL;
      end
      L_G3: begin
        c.div = DIV_MOD_LENP1; c.cond = C_ALWAYS; c.target = L_GT;
      end
      L_DOT: begin
        c.cond = C_STEPLT; c.cond_inv = 1'b1; c.target = L_DOTM;
      end
      5'd23: begin
        c.emit = 1'b1; c.act = ACT_BLACK; c.pix = PIX_BACK;
      end
      5'd24: begin
        c.emit = 1'b1; c.act = ACT_SET; c.pix = PIX_STEP; c.col = COL_PAL;
      end
      L_DOTM: begin
        c.div = DIV_MOD_LEN;
      end
      L_GT: begin
        c.cond = C_STEP0; c.cond_inv = 1'b1; c.target = L_GDLY;
      end
      5'd27: begin
        c.done_set = 1'b1; c.pal_next = 1'b1; c.phase_tgl = 1'b1;
      end
      L_GDLY: begin
        c.cond = C_CHASE; c.cond_inv = 1'b1; c.target = L_GD2;
      end
      5'd29: begin
        c.div = DIV_DLY_LEDSP1; c.cond = C_ALWAYS; c.target = L_END;
      end
      L_GD2: begin
        c.div = DIV_DLY_LEDS;
      end
      L_END: begin
        c.end_prog = 1'b1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/led_strip_chase_sequencer_top.sv]
// LED-strip chase sequencer.
// Input channel: one transfer per animation tick (restart_i clears the step,
// palette, phase and call count before the tick). Output channel: zero to
// three pixel commands per tick, the last one flagged by last_o; delay_ms_o
// and cycle_done_o are the same in every command of a tick.
// Configuration registers sit on the APB port at byte address 4*index.
// One tick is handled at a time: in_stall_o is high from the accepted
// transfer until the last command has been taken. A tick runs through a
// 32-word microprogram (5 to 14 words executed). Fill-mode entry ticks skip
// the 16-step divider; every other tick uses it twice (step wrap and delay).
// Once the microprogram ends, the commands are offered in turn, one per cycle
// while out_stall_i is low.
// While out_stall_i is high the current command holds on the outputs.
// Reset clears the sequencer state and loads the register defaults
// (segment 0..11, length 12, speed 1000, 12 LEDs, mode 0).
`default_nettype none

module led_strip_chase_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  pixel_index_o,
  output logic [2:0]  color_index_o,
  output logic [15:0] delay_ms_o,
  output logic        cycle_done_o,
  output logic        last_o
);
  import lscs_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  lscs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lscs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lscs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .pixel_index_o (pixel_index_o),
    .color_index_o (color_index_o),
    .delay_ms_o    (delay_ms_o),
    .cycle_done_o  (cycle_done_o),
    .last_o        (last_o),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

endmodule

`default_nettype wire

[rtl/lscs_regs.sv]
`default_nettype none

module lscs_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lscs_pkg::cfg_t    cfg_o
);
  import lscs_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_CHASE;
      cfg_q.reverse   <= 1'b0;
      cfg_q.seg_start <= 8'd0;
      cfg_q.seg_stop  <= 8'd11;
      cfg_q.seg_len   <= 9'd12;
      cfg_q.speed     <= 16'd1000;
      cfg_q.led_count <= 9'd12;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:      cfg_q.mode      <= pwdata[1:0];
        REG_REVERSE:   cfg_q.reverse   <= pwdata[0];
        REG_SEG_START: cfg_q.seg_start <= pwdata[7:0];
        REG_SEG_STOP:  cfg_q.seg_stop  <= pwdata[7:0];
        REG_SEG_LEN:   cfg_q.seg_len   <= pwdata[LEN_W-1:0];
        REG_SPEED:     cfg_q.speed     <= pwdata[15:0];
        REG_LED_COUNT: cfg_q.led_count <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MODE:      prdata = {30'd0, cfg_q.mode};
      REG_REVERSE:   prdata = {31'd0, cfg_q.reverse};
      REG_SEG_START: prdata = {24'd0, cfg_q.seg_start};
      REG_SEG_STOP:  prdata = {24'd0, cfg_q.seg_stop};
      REG_SEG_LEN:   prdata = {23'd0, cfg_q.seg_len};
      REG_SPEED:     prdata = {16'd0, cfg_q.speed};
      REG_LED_COUNT: prdata = {23'd0, cfg_q.led_count};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/lscs_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lscs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lscs_pkg::div_req_t req_i,
  output lscs_pkg::div_rsp_t rsp_o
);
  import lscs_pkg::*;

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q, dvs_q;
  logic [DIVS_W:0]   trial, rem_nx;
  logic              ge;

  assign trial  = {rem_q, quo_q[DIVD_W-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign rem_nx = ge ? (trial - {1'b0, dvs_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {DCNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= rem_nx[DIVS_W-1:0];
    end
  end

  assign rsp_o = {done_q, quo_q, rem_q};

endmodule

`default_nettype wire

[rtl/lscs_seq.sv]
`default_nettype none

module lscs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lscs_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         action_o,
  output logic [7:0]         pixel_index_o,
  output logic [2:0]         color_index_o,
  output logic [15:0]        delay_ms_o,
  output logic               cycle_done_o,
  output logic               last_o,
  output lscs_pkg::div_req_t div_req_o,
  input  lscs_pkg::div_rsp_t div_rsp_i
);
  import lscs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [LEN_W-1:0] step_q, step_d;
  logic [PAL_W-1:0] pal_q, pal_d;
  logic             phase_q, phase_d;
  logic [1:0]       calls_q, calls_d;
  logic             done_q, done_d;
  logic [15:0]      delay_q, delay_d;
  logic [NCNT_W-1:0] n_q, n_d;
  logic [NCNT_W-1:0] oidx_q, oidx_d;
  logic             dwait_q, dwait_d;

  act_e             act_q [MAX_RES];
  logic [7:0]       pix_q [MAX_RES];
  logic [PAL_W-1:0] col_q [MAX_RES];

  cw_t              cw;
  logic [LEN_W-1:0] len_eff, leds_eff;
  logic [DIVS_W-1:0] len10, leds10;
  logic             cond_val, taken, hold, emit_we, is_last;
  logic             div_start;
  logic [PAL_W:0]   pal_inc;
  logic             pal_wrap;
  logic [PAL_W-1:0] pal_nx;
  logic [LEN_W-1:0] off;
  logic [7:0]       pix;
  logic [PAL_W-1:0] col;
  logic [DIVS_W-1:0] step_inc;

  assign cw = lscs_rom(pc_q);

  always_comb begin
    if (cfg_i.seg_len < MIN_LEN) len_eff = MIN_LEN;
    else if (cfg_i.seg_len > MAX_LEDS) len_eff = MAX_LEDS;
    else len_eff = cfg_i.seg_len;
    leds_eff = (cfg_i.led_count < MIN_LEN) ? MIN_LEN : cfg_i.led_count;
  end

  assign len10    = {1'b0, len_eff};
  assign leds10   = {1'b0, leds_eff};
  assign step_inc = {1'b0, step_q} + 10'd1;
  assign pal_inc  = {1'b0, pal_q} + 4'd1;
  assign pal_wrap = pal_inc >= PALETTE_SIZE;
  assign pal_nx   = pal_wrap ? '0 : pal_inc[PAL_W-1:0];

  always_comb begin
    unique case (cw.cond)
      C_NONE:     cond_val = 1'b0;
      C_ALWAYS:   cond_val = 1'b1;
      C_MODE1:    cond_val = cfg_i.mode == MODE_FILL;
      C_MODE3:    cond_val = cfg_i.mode == MODE_ALT;
      C_CALLS0:   cond_val = calls_q == 2'd0;
      C_CALLS1:   cond_val = calls_q == 2'd1;
      C_STEP0:    cond_val = step_q == '0;
      C_STEPLT:   cond_val = step_q < len_eff;
      C_STEPLAST: cond_val = step_q >= (len_eff - 9'd1);
      C_CHASE:    cond_val = (cfg_i.mode == MODE_CHASE) ||
                             ((cfg_i.mode == MODE_ALT) && !phase_q);
      default:    cond_val = 1'b0;
    endcase
  end

  assign taken = (cw.cond != C_NONE) && (cond_val ^ cw.cond_inv);

  // offset within the segment, then absolute address (wraps mod 256)
  always_comb begin
    unique case (cw.pix)
      PIX_HEAD: off = '0;
      PIX_STEP: off = step_q;
      PIX_BACK: off = (step_q == '0) ? (len_eff - 9'd1) : (step_q - 9'd1);
      default:  off = '0;
    endcase
    if (cw.pix == PIX_NONE) pix = 8'd0;
    else if (cfg_i.reverse) pix = cfg_i.seg_stop - off[7:0];
    else pix = cfg_i.seg_start + off[7:0];
  end

  always_comb begin
    unique case (cw.col)
      COL_PAL:  col = pal_q;
      COL_NEXT: col = pal_nx;
      default:  col = '0;
    endcase
  end

  always_comb begin
    div_req_o.start    = div_start;
    div_req_o.dividend = {6'd0, step_inc};
    div_req_o.divisor  = len10;
    case (cw.div)
      DIV_MOD_LEN:    div_req_o.divisor = len10;
      DIV_MOD_LENP1:  div_req_o.divisor = len10 + 10'd1;
      DIV_DLY_LEDS:   div_req_o.divisor = leds10;
      DIV_DLY_LEDSP1: div_req_o.divisor = leds10 + 10'd1;
      DIV_DLY_LEDSM1: div_req_o.divisor = leds10 - 10'd1;
      default:        div_req_o.divisor = len10;
    endcase
    if (cw.div == DIV_DLY_LEDS || cw.div == DIV_DLY_LEDSP1 || cw.div == DIV_DLY_LEDSM1) begin
      div_req_o.dividend = cfg_i.speed;
    end
  end

  assign hold    = (cw.div != DIV_NONE) && !(dwait_q && div_rsp_i.done);
  assign is_last = oidx_q == (n_q - 2'd1);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    step_d  = step_q;
    pal_d   = pal_q;
    phase_d = phase_q;
    calls_d = calls_q;
    done_d  = done_q;
    delay_d = delay_q;
    n_d     = n_q;
    oidx_d  = oidx_q;
    dwait_d = dwait_q;
    emit_we = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RUN;
          pc_d    = '0;
          n_d     = '0;
          done_d  = 1'b0;
          dwait_d = 1'b0;
          if (restart_i) begin
            step_d  = '0;
            pal_d   = '0;
            phase_d = 1'b0;
            calls_d = '0;
          end
        end
      end
      S_RUN: begin
        if (cw.div != DIV_NONE && !dwait_q) begin
          div_start = 1'b1;
          dwait_d = 1'b1;
        end
        if (!hold) begin
          dwait_d = 1'b0;
          if (cw.emit && n_q < NCNT_W'(MAX_RES)) begin
            emit_we = 1'b1;
            n_d = n_q + 1'b1;
          end
          if (cw.pal_next) pal_d = pal_nx;
          if (cw.done_set) done_d = 1'b1;
          if (cw.phase_tgl && cfg_i.mode == MODE_ALT && pal_wrap) phase_d = !phase_q;
          if (cw.step_set1) step_d = 9'd1;
          if (cw.dly_speed) delay_d = cfg_i.speed;
          case (cw.div) inside
            DIV_MOD_LEN, DIV_MOD_LENP1: step_d = div_rsp_i.rem[LEN_W-1:0];
            DIV_DLY_LEDS, DIV_DLY_LEDSP1, DIV_DLY_LEDSM1: delay_d = div_rsp_i.quo;
            default: ;
          endcase
          pc_d = taken ? cw.target : (pc_q + 1'b1);
          if (cw.end_prog) begin
            if (calls_q < CALLS_SAT) calls_d = calls_q + 2'd1;
            oidx_d  = '0;
            state_d = (n_q == '0) ? S_IDLE : S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (is_last) state_d = S_IDLE;
          else oidx_d = oidx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      step_q  <= '0;
      pal_q   <= '0;
      phase_q <= 1'b0;
      calls_q <= '0;
      done_q  <= 1'b0;
      n_q     <= '0;
      oidx_q  <= '0;
      dwait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      step_q  <= step_d;
      pal_q   <= pal_d;
      phase_q <= phase_d;
      calls_q <= calls_d;
      done_q  <= done_d;
      n_q     <= n_d;
      oidx_q  <= oidx_d;
      dwait_q <= dwait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q <= delay_d;
    if (emit_we) begin
      act_q[n_q] <= cw.act;
      pix_q[n_q] <= pix;
      col_q[n_q] <= col;
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = state_q == S_OUT;
  assign action_o      = act_q[oidx_q];
  assign pixel_index_o = pix_q[oidx_q];
  assign color_index_o = col_q[oidx_q];
  assign delay_ms_o    = delay_q;
  assign cycle_done_o  = done_q;
  assign last_o        = is_last;

endmodule

`default_nettype wire

[rtl/lscs_chk.sv]
`default_nettype none

`include "led_strip_chase_sequencer_top_defines.svh"

module lscs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [7:0]  pixel_index_o,
  input logic [2:0]  color_index_o,
  input logic        last_o
);
  import lscs_pkg::*;

  // no new tick while commands of the current one are pending
  `LSCS_ASSERT_IMPL(a_out_blocks_in, out_valid_o, in_stall_o)
  // an accepted tick keeps the input side busy
  `LSCS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // clear-all carries neither pixel nor color
  `LSCS_ASSERT_IMPL(a_clear_fields,
                    out_valid_o && action_o == ACT_CLEAR,
                    pixel_index_o == 8'd0 && color_index_o == 3'd0)
  `LSCS_ASSERT_IMPL(a_color_range, out_valid_o, {1'b0, color_index_o} < PALETTE_SIZE)
  `LSCS_ASSERT_NEXT(a_stall_holds,
                    out_valid_o && out_stall_i,
                    out_valid_o && $stable(action_o) && $stable(pixel_index_o) && $stable(last_o))

endmodule

bind led_strip_chase_sequencer_top lscs_chk u_lscs_chk (.*);

`default_nettype wire

[dv/led_strip_chase_sequencer_top_test.sv]
`timescale 1ns / 1ps

module led_strip_chase_sequencer_top_test;
  import lscs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_TICKS  = 340;

  typedef struct {
    bit restart;
    bit drain;
  } tick_req_t;

  typedef struct packed {
    act_e        act;
    logic [7:0]  pix;
    logic [2:0]  col;
    logic [15:0] dly;
    logic        done;
    logic        last;
  } pixel_cmd_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic [7:0]  pixel_index_o;
  logic [2:0]  color_index_o;
  logic [15:0] delay_ms_o;
  logic        cycle_done_o;
  logic        last_o;

  led_strip_chase_sequencer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .pixel_index_o (pixel_index_o),
    .color_index_o (color_index_o),
    .delay_ms_o    (delay_ms_o),
    .cycle_done_o  (cycle_done_o),
    .last_o        (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register mirror, reset values
  logic [1:0]  cfg_mode  = MODE_CHASE;
  logic        cfg_rev   = 1'b0;
  logic [7:0]  cfg_start = 8'd0;
  logic [7:0]  cfg_stop  = 8'd11;
  logic [8:0]  cfg_len   = 9'd12;
  logic [15:0] cfg_speed = 16'd1000;
  logic [8:0]  cfg_leds  = 9'd12;

  // sequencer state
  int unsigned seq_step = 0;
  int unsigned pal_pos  = 0;
  bit          alt_dot  = 1'b0;
  int unsigned calls    = 0;

  tick_req_t   ticks_to_send[$];
  pixel_cmd_t  cmds_expected[$];
  pixel_cmd_t  tick_cmds[$];

  int err_count = 0;
  int cycles    = 0;
  int send_gap  = 0;
  int recv_wait = 0;
  bit no_idle   = 1'b0;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] strip_pixel(int unsigned k);
    return cfg_rev ? cfg_stop - 8'(k) : cfg_start + 8'(k);
  endfunction

  function automatic int unsigned next_pal(int unsigned p);
    return (p + 1 >= PALETTE_SIZE) ? 0 : p + 1;
  endfunction

  function automatic void add_cmd(act_e a, logic [7:0] p, int unsigned c);
    pixel_cmd_t cmd;
    cmd = '0;
    cmd.act = a;
    cmd.pix = p;
    cmd.col = 3'(c);
    if (tick_cmds.size() < MAX_RES) tick_cmds.push_back(cmd);
  endfunction

  function automatic void chase_step(int unsigned len);
    if (seq_step < len) add_cmd(ACT_SET, strip_pixel(seq_step), pal_pos);
    else add_cmd(ACT_CLEAR, 8'd0, 0);
    seq_step = (seq_step + 1) % (len + 1);
  endfunction

  function automatic void dot_step(int unsigned len);
    int unsigned back;
    if (seq_step < len) begin
      // wrap-around erases the segment's last pixel
      back = (seq_step == 0) ? len - 1 : seq_step - 1;
      add_cmd(ACT_BLACK, strip_pixel(back), 0);
      add_cmd(ACT_SET, strip_pixel(seq_step), pal_pos);
    end
    seq_step = (seq_step + 1) % len;
  endfunction

  function automatic void predict_tick(bit restart);
    int unsigned len;
    int unsigned leds;
    int unsigned dly;
    bit          done;
    bit          early;
    pixel_cmd_t  cmd;
    len   = (cfg_len < MIN_LEN) ? MIN_LEN : (cfg_len > MAX_LEDS) ? MAX_LEDS : cfg_len;
    leds  = (cfg_leds < 2) ? 2 : cfg_leds;
    dly   = 0;
    done  = 1'b0;
    early = 1'b0;
    tick_cmds.delete();
    if (restart) begin
      seq_step = 0;
      pal_pos  = 0;
      alt_dot  = 1'b0;
      calls    = 0;
    end
    if (cfg_mode == MODE_FILL) begin
      if (calls == 0) begin
        add_cmd(ACT_FILL, 8'd0, pal_pos);
        pal_pos = next_pal(pal_pos);
        dly     = cfg_speed;
        early   = 1'b1;
      end else if (seq_step == 0) begin
        add_cmd(ACT_SET, strip_pixel(0), pal_pos);
        seq_step = 1;
        if (calls == 1) begin
          dly   = cfg_speed;
          early = 1'b1;
        end
      end
      if (!early) begin
        if (seq_step < len) begin
          add_cmd(ACT_SET, strip_pixel(seq_step), pal_pos);
          if (seq_step >= len - 1) add_cmd(ACT_SET, strip_pixel(0), next_pal(pal_pos));
        end
        seq_step = (seq_step + 1) % len;
        if (seq_step == 0) begin
          done    = 1'b1;
          pal_pos = next_pal(pal_pos);
        end
        dly = cfg_speed / (leds - 1);
      end
    end else begin
      if (cfg_mode == MODE_CHASE) begin
        chase_step(len);
      end else if (cfg_mode == MODE_DOT) begin
        dot_step(len);
      end else begin
        if (seq_step == 0) add_cmd(ACT_CLEAR, 8'd0, 0);
        if (!alt_dot) chase_step(len);
        else dot_step(len);
      end
      if (seq_step == 0) begin
        done = 1'b1;
        if (pal_pos + 1 >= PALETTE_SIZE) begin
          pal_pos = 0;
          if (cfg_mode == MODE_ALT) alt_dot = ~alt_dot;
        end else begin
          pal_pos = pal_pos + 1;
        end
      end
      if (cfg_mode == MODE_CHASE || (cfg_mode == MODE_ALT && !alt_dot))
        dly = cfg_speed / (leds + 1);
      else
        dly = cfg_speed / leds;
    end
    if (calls < CALLS_SAT) calls = calls + 1;
    foreach (tick_cmds[i]) begin
      cmd      = tick_cmds[i];
      cmd.dly  = 16'(dly);
      cmd.done = done;
      cmd.last = (i == tick_cmds.size() - 1);
      cmds_expected.push_back(cmd);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // tick driver
  always @(posedge clk_i) begin : drv
    tick_req_t req;
    bit        nxt_valid;
    bit        nxt_restart;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
      send_gap   = 0;
    end else begin
      nxt_valid   = in_valid_i;
      nxt_restart = restart_i;
      if (in_valid_i && !in_stall_o) begin
        predict_tick(restart_i);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ticks_to_send.size() > 0 &&
                     !(ticks_to_send[0].drain && cmds_expected.size() > 0)) begin
          req         = ticks_to_send.pop_front();
          nxt_valid   = 1'b1;
          nxt_restart = req.restart;
          send_gap    = draw_wait();
        end
      end
      in_valid_i <= nxt_valid;
      restart_i  <= nxt_restart;
    end
  end

  // command monitor
  always @(posedge clk_i) begin : mon
    pixel_cmd_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cmds_expected.size() == 0) begin
          $display("%0t unexpected command: action %0d pixel %0d color %0d", $time,
                   action_o, pixel_index_o, color_index_o);
          err_count++;
        end else begin
          want = cmds_expected.pop_front();
          check_field("action", want.act, action_o);
          check_field("pixel_index", want.pix, pixel_index_o);
          check_field("color_index", want.col, color_index_o);
          check_field("delay_ms", want.dly, delay_ms_o);
          check_field("cycle_done", want.done, cycle_done_o);
          check_field("last", want.last, last_o);
        end
        recv_wait = draw_wait();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:      cfg_mode  = val[1:0];
      REG_REVERSE:   cfg_rev   = val[0];
      REG_SEG_START: cfg_start = val[7:0];
      REG_SEG_STOP:  cfg_stop  = val[7:0];
      REG_SEG_LEN:   cfg_len   = val[8:0];
      REG_SPEED:     cfg_speed = val[15:0];
      REG_LED_COUNT: cfg_leds  = val[8:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int m, input int rev, input int first, input int stop,
                           input int len, input int spd, input int leds);
    reg_write(REG_MODE, m);
    reg_write(REG_REVERSE, rev);
    reg_write(REG_SEG_START, first);
    reg_write(REG_SEG_STOP, stop);
    reg_write(REG_SEG_LEN, len);
    reg_write(REG_SPEED, spd);
    reg_write(REG_LED_COUNT, leds);
  endtask

  // block is idle once every tick went out and every command came back; a tick
  // with no command may still be running, so let it finish
  task automatic wait_idle();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid_i || cmds_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stim
    int n_rand;
    int plen;
    bit first_phase;
    bit rst_tick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // chase on a two-pixel segment (length and LED count below range)
    write_all(MODE_CHASE, 0, 0, 255, 0, 65535, 0);
    ticks_to_send.push_back('{1'b1, 1'b0});
    repeat (3) ticks_to_send.push_back('{1'b0, 1'b0});
    wait_idle();

    // fill entry, early head, pass end with recolored head; reverse wraps below 0
    write_all(MODE_FILL, 1, 255, 0, 3, 1000, 1);
    ticks_to_send.push_back('{1'b1, 1'b0});
    repeat (3) ticks_to_send.push_back('{1'b0, 1'b0});
    ticks_to_send.push_back('{1'b0, 1'b1});
    wait_idle();

    // dot wrap erases the last pixel, forward addressing wraps past 255
    write_all(MODE_DOT, 0, 254, 0, 3, 0, 2);
    ticks_to_send.push_back('{1'b1, 1'b0});
    repeat (3) ticks_to_send.push_back('{1'b0, 1'b0});
    wait_idle();

    // step left beyond a shrunken segment: no commands for that tick
    reg_write(REG_SEG_LEN, 8);
    ticks_to_send.push_back('{1'b1, 1'b0});
    repeat (4) ticks_to_send.push_back('{1'b0, 1'b0});
    wait_idle();
    reg_write(REG_SEG_LEN, 2);
    repeat (2) ticks_to_send.push_back('{1'b0, 1'b0});
    wait_idle();

    // alternating mode, segment length above range, LED count at its maximum
    write_all(MODE_ALT, 1, 0, 255, 511, 12345, 511);
    ticks_to_send.push_back('{1'b1, 1'b0});
    repeat (2) ticks_to_send.push_back('{1'b0, 1'b0});

    n_rand      = 0;
    first_phase = 1'b1;
    while (n_rand < RANDOM_TICKS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      if (first_phase) begin
        // long enough in a short segment to cross into the dot phase and back
        write_all(MODE_ALT, $urandom_range(0, 1), $urandom_range(0, 255),
                  $urandom_range(0, 255), 2, $urandom_range(0, 65535),
                  $urandom_range(0, 511));
        plen = 45;
      end else begin
        if ($urandom_range(0, 2) != 0) reg_write(REG_MODE, $urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) reg_write(REG_REVERSE, $urandom_range(0, 1));
        if ($urandom_range(0, 2) != 0) reg_write(REG_SEG_START, $urandom_range(0, 255));
        if ($urandom_range(0, 2) != 0) reg_write(REG_SEG_STOP, $urandom_range(0, 255));
        if ($urandom_range(0, 2) != 0)
          case ($urandom_range(0, 9))
            0:       reg_write(REG_SEG_LEN, $urandom_range(0, 1));
            1:       reg_write(REG_SEG_LEN, $urandom_range(256, 511));
            2:       reg_write(REG_SEG_LEN, $urandom_range(7, 40));
            default: reg_write(REG_SEG_LEN, $urandom_range(2, 6));
          endcase
        if ($urandom_range(0, 2) != 0)
          case ($urandom_range(0, 5))
            0:       reg_write(REG_SPEED, 0);
            1:       reg_write(REG_SPEED, 65535);
            default: reg_write(REG_SPEED, $urandom_range(0, 65535));
          endcase
        if ($urandom_range(0, 2) != 0)
          case ($urandom_range(0, 5))
            0:       reg_write(REG_LED_COUNT, $urandom_range(0, 1));
            1:       reg_write(REG_LED_COUNT, $urandom_range(21, 511));
            default: reg_write(REG_LED_COUNT, $urandom_range(2, 20));
          endcase
        plen = $urandom_range(15, 45);
      end
      for (int i = 0; i < plen; i++) begin
        if (first_phase) rst_tick = (i == 0);
        else if (i == 0) rst_tick = $urandom_range(0, 1);
        else rst_tick = ($urandom_range(0, 19) == 0);
        ticks_to_send.push_back('{rst_tick, ($urandom_range(0, 24) == 0)});
      end
      n_rand      += plen;
      first_phase = 1'b0;
    end
    wait_idle();

    if (cmds_expected.size() != 0) begin
      $display("%0t %0d commands never arrived", $time, cmds_expected.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lscs_pkg.sv
rtl/lscs_regs.sv
rtl/lscs_div.sv
rtl/lscs_seq.sv
rtl/led_strip_chase_sequencer_top.sv
rtl/lscs_chk.sv
dv/led_strip_chase_sequencer_top_test.sv
